[rtl/pchm_pkg.sv]
// ----------------------------------------------------------------------------
// pchm_pkg
// Shared types, codes and sizes of the per-channel hit time merger.
// ----------------------------------------------------------------------------
package pchm_pkg;

   localparam int FIBERS     = 32;
   localparam int FIB_AW     = (FIBERS > 1) ? $clog2(FIBERS) : 1;
   localparam int CSR_IW     = 8;
   localparam int CSR_DW     = 24;
   localparam int FIFO_DEPTH = 2;
   localparam int FIFO_AW    = 1;
   localparam int FIFO_CW    = 2;

   localparam logic CMD_HIT      = 1'b0;
   localparam logic CMD_FLUSH    = 1'b1;
   localparam logic KIND_CLUSTER = 1'b0;
   localparam logic KIND_MARKER  = 1'b1;

   localparam logic [15:0] MERGE_WINDOW_RESET = 16'd480;
   localparam logic [23:0] ENERGY_FLOOR_RESET = 24'd1;
   localparam logic [15:0] X_OFFSET_RESET     = 16'd0;
   localparam logic [15:0] X_PITCH_RESET      = 16'd256;

   typedef enum logic [CSR_IW-1:0] {
      CSR_MERGE_WINDOW = 8'd0,
      CSR_ENERGY_FLOOR = 8'd1,
      CSR_X_OFFSET     = 8'd2,
      CSR_X_PITCH      = 8'd3
   } csr_index_type;

   typedef struct packed {
      logic [15:0]        merge_window;
      logic [23:0]        energy_floor;
      logic signed [15:0] x_offset;
      logic [15:0]        x_pitch;
   } cfg_type;

   typedef struct packed {
      logic               command;
      logic [4:0]         fiber;
      logic [23:0]        energy;
      logic [23:0]        hit_time;
      logic signed [15:0] y;
   } op_type;

   typedef struct packed {
      logic [23:0]        energy;
      logic [23:0]        start;
      logic signed [15:0] y;
   } entry_type;

   typedef struct packed {
      logic               kind;
      logic [4:0]         fiber_out;
      logic signed [15:0] x_pos;
      logic signed [15:0] y_pos;
      logic [23:0]        energy_out;
      logic [23:0]        time_out;
      logic               last;
   } rsp_item_type;

   typedef struct packed {
      logic   push;
      logic   full;
      op_type push_op;
   } push_ch_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_HIT_UPDATE,
      BK_FLUSH_READ,
      BK_FLUSH_EMIT,
      BK_MARK
   } back_state_type;

endpackage

[rtl/pchm_if.sv]
// ----------------------------------------------------------------------------
// pchm_if
// Channel interfaces: hit request, result and register write.
// ----------------------------------------------------------------------------
interface pchm_req_if;
   logic               valid;
   logic               ready;
   logic               command;
   logic [4:0]         fiber;
   logic [23:0]        energy_in;
   logic [23:0]        time_in;
   logic signed [15:0] y_in;

   modport source (output valid, command, fiber, energy_in, time_in, y_in, input ready);
   modport sink   (input valid, command, fiber, energy_in, time_in, y_in, output ready);
endinterface

interface pchm_rsp_if;
   logic               valid;
   logic               ready;
   logic               kind;
   logic [4:0]         fiber_out;
   logic signed [15:0] x_pos;
   logic signed [15:0] y_pos;
   logic [23:0]        energy_out;
   logic [23:0]        time_out;
   logic               last;

   modport source (output valid, kind, fiber_out, x_pos, y_pos, energy_out, time_out, last,
                   input ready);
   modport sink   (input valid, kind, fiber_out, x_pos, y_pos, energy_out, time_out, last,
                   output ready);
endinterface

interface pchm_csr_if;
   import pchm_pkg::*;
   logic              valid;
   logic              ready;
   logic [CSR_IW-1:0] index;
   logic [CSR_DW-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

[rtl/per_channel_hit_time_merger_core.sv]
// ----------------------------------------------------------------------------
// per_channel_hit_time_merger_core
// Per-fibre pile-up merger of time-ordered hits within a time window.
// ----------------------------------------------------------------------------
// Usage
//   req_ch carries hits (command hit) and end-of-event flushes (command
//   flush); rsp_ch returns merged clusters and one end-of-event marker per
//   flush; csr_ch writes merge_window, energy_floor, x_offset and x_pitch,
//   one write per cycle; the user must write only while the block is idle,
//   which the block itself does not enforce. A hit reads the fibre entry
//   from the cluster store (registered read port) in the idle state, then
//   writes it back in the update state and, if it closes a cluster, loads
//   the result register. A hit passes from the queue through the entry read
//   register to the result register. A flush walks every fibre in a read
//   and an emit state, then sends the end-of-event marker.
//   Hits below the floor or off the fibre range are dropped in the front end
//   and never reach the back end.
//   Reset clears all open-cluster flags, the queue and the result valid flag,
//   and restores register defaults; the cluster store needs no clearing.
//   When rsp_ch stalls, the back end holds at its next result; the two-entry
//   queue keeps taking requests until it fills.
// ----------------------------------------------------------------------------
module per_channel_hit_time_merger_core (
   input logic        clock,
   input logic        reset,
   pchm_req_if.sink   req_ch,
   pchm_rsp_if.source rsp_ch,
   pchm_csr_if.sink   csr_ch
);
   import pchm_pkg::*;

   cfg_type     cfg;
   push_ch_type push_ch;
   op_type      head;
   logic        full;
   logic        empty;
   logic        pop;

   pchm_front u_front (
      .clock   (clock),
      .reset   (reset),
      .req     (req_ch),
      .csr     (csr_ch),
      .full    (full),
      .push_ch (push_ch),
      .cfg     (cfg)
   );

   pchm_fifo u_fifo (
      .clock   (clock),
      .reset   (reset),
      .push_ch (push_ch),
      .pop     (pop),
      .full    (full),
      .empty   (empty),
      .head    (head)
   );

   pchm_back u_back (
      .clock (clock),
      .reset (reset),
      .cfg   (cfg),
      .head  (head),
      .empty (empty),
      .pop   (pop),
      .rsp   (rsp_ch)
   );

endmodule

[rtl/pchm_front.sv]
// ----------------------------------------------------------------------------
// pchm_front
// Register file and request classifier: drops hits below the floor or off
// the fibre range, queues hits and flush commands for the back end.
// ----------------------------------------------------------------------------
module pchm_front (
   input  logic                  clock,
   input  logic                  reset,
   pchm_req_if.sink              req,
   pchm_csr_if.sink              csr,
   input  logic                  full,
   output pchm_pkg::push_ch_type push_ch,
   output pchm_pkg::cfg_type     cfg
);
   import pchm_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;
   logic    keep;

   assign csr.ready = 1'b1;
   assign req.ready = !full;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr.valid) begin
         case (csr.index)
            CSR_MERGE_WINDOW: cfg_in.merge_window = csr.data[15:0];
            CSR_ENERGY_FLOOR: cfg_in.energy_floor = csr.data[23:0];
            CSR_X_OFFSET:     cfg_in.x_offset     = $signed(csr.data[15:0]);
            CSR_X_PITCH:      cfg_in.x_pitch      = csr.data[15:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.merge_window <= MERGE_WINDOW_RESET;
         cfg_ff.energy_floor <= ENERGY_FLOOR_RESET;
         cfg_ff.x_offset     <= $signed(X_OFFSET_RESET);
         cfg_ff.x_pitch      <= X_PITCH_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // classify: flush always passes, a hit needs energy and a valid fibre
   assign keep = (req.command == CMD_FLUSH) ||
                 ((req.energy_in >= cfg_ff.energy_floor) && ({1'b0, req.fiber} < 6'(FIBERS)));

   assign push_ch.push             = req.valid && !full && keep;
   assign push_ch.full             = full;
   assign push_ch.push_op.command  = req.command;
   assign push_ch.push_op.fiber    = req.fiber;
   assign push_ch.push_op.energy   = req.energy_in;
   assign push_ch.push_op.hit_time = req.time_in;
   assign push_ch.push_op.y        = req.y_in;
   assign cfg                      = cfg_ff;

endmodule

[rtl/pchm_fifo.sv]
// ----------------------------------------------------------------------------
// pchm_fifo
// Short command queue between front and back end.
// ----------------------------------------------------------------------------
module pchm_fifo (
   input  logic                  clock,
   input  logic                  reset,
   input  pchm_pkg::push_ch_type push_ch,
   input  logic                  pop,
   output logic                  full,
   output logic                  empty,
   output pchm_pkg::op_type      head
);
   import pchm_pkg::*;

   op_type               slot_ff [FIFO_DEPTH];
   logic [FIFO_AW-1:0]   wr_ptr_ff;
   logic [FIFO_AW-1:0]   rd_ptr_ff;
   logic [FIFO_CW-1:0]   count_ff;
   logic [FIFO_CW-1:0]   count_in;
   logic                 do_pop;

   assign full   = (count_ff == FIFO_CW'(FIFO_DEPTH));
   assign empty  = (count_ff == '0);
   assign head   = slot_ff[rd_ptr_ff];
   assign do_pop = pop && !empty;

   always_comb begin
      count_in = count_ff;
      if (push_ch.push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push_ch.push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push_ch.push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push_ch.push) begin
         slot_ff[wr_ptr_ff] <= push_ch.push_op;
      end
   end

endmodule

[rtl/pchm_back.sv]
// ----------------------------------------------------------------------------
// pchm_back
// Cluster store and sequencer: read-modify-write of one fibre entry per hit,
// fibre walk on flush, end-of-event marker, result register.
// ----------------------------------------------------------------------------
module pchm_back (
   input  logic              clock,
   input  logic              reset,
   input  pchm_pkg::cfg_type cfg,
   input  pchm_pkg::op_type  head,
   input  logic              empty,
   output logic              pop,
   pchm_rsp_if.source        rsp
);
   import pchm_pkg::*;

   back_state_type    state_ff;
   back_state_type    state_in;
   op_type            op_ff;
   logic [FIB_AW-1:0] idx_ff;
   entry_type         rd_ff;
   entry_type         mem [FIBERS];
   logic [FIBERS-1:0] open_ff;
   rsp_item_type      out_ff;
   logic              out_valid_ff;

   logic              rd_en;
   logic [FIB_AW-1:0] rd_addr;
   logic              wr_en;
   entry_type         wr_data;
   logic              open_set;
   logic              open_clr;
   logic              idx_clr;
   logic              idx_inc;
   logic              load_out;
   rsp_item_type      out_item;

   logic [FIB_AW-1:0] head_addr;
   logic [FIB_AW-1:0] hit_addr;
   logic [FIB_AW-1:0] cur_addr;
   logic              hit_open;
   logic              early;
   logic [23:0]       diff;
   logic              merge;
   logic [24:0]       sum;
   logic [23:0]       sum_sat;
   logic              above;
   logic              hit_emit;
   logic              fl_emit;
   logic              fl_last;
   logic              out_free;
   rsp_item_type      cluster_item;
   rsp_item_type      marker_item;

   function automatic logic signed [15:0] x_position(input cfg_type c,
                                                     input logic [FIB_AW-1:0] f);
      logic [FIB_AW+15:0]        prod;
      logic signed [FIB_AW+17:0] total;
      prod  = (FIB_AW+16)'(f) * (FIB_AW+16)'(c.x_pitch);
      total = (FIB_AW+18)'(c.x_offset) + $signed({2'b00, prod});
      if (total > 32767) begin
         return 16'sh7FFF;
      end else if (total < -32768) begin
         return -16'sh8000;
      end else begin
         return $signed(total[15:0]);
      end
   endfunction

   assign head_addr = FIB_AW'({1'b0, head.fiber});
   assign hit_addr  = FIB_AW'({1'b0, op_ff.fiber});
   assign cur_addr  = (state_ff == BK_HIT_UPDATE) ? hit_addr : idx_ff;
   assign hit_open  = open_ff[hit_addr];
   assign early     = op_ff.hit_time < rd_ff.start;
   assign diff      = op_ff.hit_time - rd_ff.start;
   assign merge     = hit_open && (early || (diff < {8'd0, cfg.merge_window}));
   assign sum       = {1'b0, rd_ff.energy} + {1'b0, op_ff.energy};
   assign sum_sat   = sum[24] ? 24'hFFFFFF : sum[23:0];
   assign above     = rd_ff.energy > cfg.energy_floor;
   assign hit_emit  = hit_open && above;
   assign fl_emit   = open_ff[idx_ff] && above;
   assign fl_last   = (idx_ff == FIB_AW'(FIBERS - 1));
   assign out_free  = !out_valid_ff || rsp.ready;

   assign cluster_item.kind       = KIND_CLUSTER;
   assign cluster_item.fiber_out  = 5'(cur_addr);
   assign cluster_item.x_pos      = x_position(cfg, cur_addr);
   assign cluster_item.y_pos      = rd_ff.y;
   assign cluster_item.energy_out = rd_ff.energy;
   assign cluster_item.time_out   = rd_ff.start;
   assign cluster_item.last       = (state_ff == BK_HIT_UPDATE);

   assign marker_item = '{kind: KIND_MARKER, last: 1'b1, default: '0};

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE: begin
            if (!empty) begin
               state_in = (head.command == CMD_FLUSH) ? BK_FLUSH_READ : BK_HIT_UPDATE;
            end
         end
         BK_HIT_UPDATE: begin
            if (merge || !hit_emit || out_free) begin
               state_in = BK_IDLE;
            end
         end
         BK_FLUSH_READ: state_in = BK_FLUSH_EMIT;
         BK_FLUSH_EMIT: begin
            if (!fl_emit || out_free) begin
               state_in = fl_last ? BK_MARK : BK_FLUSH_READ;
            end
         end
         BK_MARK: begin
            if (out_free) begin
               state_in = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   always_comb begin
      pop      = 1'b0;
      rd_en    = 1'b0;
      rd_addr  = idx_ff;
      wr_en    = 1'b0;
      wr_data  = '{energy: op_ff.energy, start: op_ff.hit_time, y: op_ff.y};
      open_set = 1'b0;
      open_clr = 1'b0;
      idx_clr  = 1'b0;
      idx_inc  = 1'b0;
      load_out = 1'b0;
      out_item = cluster_item;
      case (state_ff)
         BK_IDLE: begin
            pop     = !empty;
            rd_en   = !empty && (head.command == CMD_HIT);
            rd_addr = head_addr;
            idx_clr = !empty;
         end
         BK_HIT_UPDATE: begin
            if (merge) begin
               wr_en   = 1'b1;
               wr_data = '{energy: sum_sat,
                           start:  early ? op_ff.hit_time : rd_ff.start,
                           y:      early ? op_ff.y : rd_ff.y};
            end else if (!hit_emit || out_free) begin
               wr_en    = 1'b1;
               open_set = 1'b1;
               load_out = hit_emit;
            end
         end
         BK_FLUSH_READ: begin
            rd_en = 1'b1;
         end
         BK_FLUSH_EMIT: begin
            if (!fl_emit || out_free) begin
               open_clr = 1'b1;
               load_out = fl_emit;
               idx_inc  = !fl_last;
            end
         end
         BK_MARK: begin
            load_out = out_free;
            out_item = marker_item;
         end
         default: begin
            pop = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         idx_ff       <= '0;
         open_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (idx_clr) begin
            idx_ff <= '0;
         end else if (idx_inc) begin
            idx_ff <= idx_ff + 1'b1;
         end
         if (open_set) begin
            open_ff[hit_addr] <= 1'b1;
         end
         if (open_clr) begin
            open_ff[idx_ff] <= 1'b0;
         end
         if (load_out) begin
            out_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         op_ff <= head;
      end
      if (load_out) begin
         out_ff <= out_item;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[hit_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_ff <= mem[rd_addr];
      end
   end

   assign rsp.valid      = out_valid_ff;
   assign rsp.kind       = out_ff.kind;
   assign rsp.fiber_out  = out_ff.fiber_out;
   assign rsp.x_pos      = out_ff.x_pos;
   assign rsp.y_pos      = out_ff.y_pos;
   assign rsp.energy_out = out_ff.energy_out;
   assign rsp.time_out   = out_ff.time_out;
   assign rsp.last       = out_ff.last;

`ifndef SYNTH
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      load_out |-> out_free)
      else $error("result register overwritten while a transfer is pending");

   a_marker_clean: assert property (@(posedge clock) disable iff (reset)
      (load_out && (out_item.kind == KIND_MARKER)) |-> (open_ff == '0))
      else $error("end-of-event marker with a cluster still open");

   a_update_after_read: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_HIT_UPDATE) |->
         ($past(state_ff) == BK_IDLE || $past(state_ff) == BK_HIT_UPDATE))
      else $error("hit update without a preceding entry read");

   a_walk_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_FLUSH_EMIT) |=> (idx_ff <= FIB_AW'(FIBERS - 1)))
      else $error("flush walk index beyond the last fibre");
`endif

endmodule
